/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PRLE_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define PRLE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/prle_pkg.sv */
// ----------------------------------------------------------------------------
// prle_pkg
// Types, widths and helpers shared by the palette run-length encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prle_pkg;

    localparam int PALETTE_SIZE  = 256;
    localparam int IDX_W         = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int USED_W        = $clog2(PALETTE_SIZE + 1);
    localparam int CHAN_W        = 8;
    localparam int COLOR_W       = 16;
    localparam int RUN_W         = 16;
    localparam int COLOR_INDEX_W = 8;
    localparam int RED_SHIFT     = 11;
    localparam int GREEN_SHIFT   = 5;

    localparam logic [RUN_W-1:0] MAX_RUN = {RUN_W{1'b1}};

    // one palette slot as it travels down the chain
    typedef struct packed {
        logic               occ;
        logic [COLOR_W-1:0] color;
    } cell_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } pal_ctrl_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] pos;
        logic             full;
    } pal_status_t;

    typedef struct packed {
        logic [RUN_W-1:0]         run_length;
        logic [COLOR_INDEX_W-1:0] color_index;
        logic [COLOR_W-1:0]       color_565;
        logic                     new_color;
        logic                     palette_overflow;
        logic                     last_run;
    } record_t;

    function automatic logic [COLOR_W-1:0] to565(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        logic [COLOR_W-1:0] c;
        c = (COLOR_W'(r[CHAN_W-1:3]) << RED_SHIFT)
          | (COLOR_W'(g[CHAN_W-1:2]) << GREEN_SHIFT)
          | COLOR_W'(b[CHAN_W-1:3]);
        return c;
    endfunction

endpackage

/* design/prle_pixel_if.sv */
// ----------------------------------------------------------------------------
// prle_pixel_if
// Pixel channel: valid/ready handshake with RGB888 payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface prle_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;

    modport source (output valid, red, green, blue, last_pixel, input ready);
    modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

/* design/prle_record_if.sv */
// ----------------------------------------------------------------------------
// prle_record_if
// Record channel: valid/ready handshake with one run record as payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface prle_record_if;
    logic        valid;
    logic        ready;
    logic [15:0] run_length;
    logic [7:0]  color_index;
    logic [15:0] color_565;
    logic        new_color;
    logic        palette_overflow;
    logic        last_run;

    modport source (output valid, run_length, color_index, color_565, new_color,
                    palette_overflow, last_run, input ready);
    modport sink   (input valid, run_length, color_index, color_565, new_color,
                    palette_overflow, last_run, output ready);
endinterface

/* design/prle_cell.sv */
// ----------------------------------------------------------------------------
// prle_cell
// One palette slot: holds a color, compares it with the key, hands its
// contents to the next slot when a new color is pushed in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prle_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  prle_pkg::pal_ctrl_t        ctrl,
    input  prle_pkg::cell_t            prev,
    input  logic [prle_pkg::COLOR_W-1:0] key,
    output prle_pkg::cell_t            cur,
    output logic                       match
);
    import prle_pkg::*;

    logic               occ_reg;
    logic [COLOR_W-1:0] color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            occ_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            occ_reg <= prev.occ;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            color_reg <= prev.color;
        end
    end

    assign cur.occ   = occ_reg;
    assign cur.color = color_reg;
    assign match     = occ_reg && (color_reg == key);

endmodule

/* design/prle_palette.sv */
// ----------------------------------------------------------------------------
// prle_palette
// Chain of palette cells. Newest color sits in cell 0; a hit reports the
// cell position, from which the caller derives the palette index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prle_palette (
    input  logic                         clk,
    input  logic                         rst_n,
    input  prle_pkg::pal_ctrl_t          ctrl,
    input  logic [prle_pkg::COLOR_W-1:0] key,
    output prle_pkg::pal_status_t        status
);
    import prle_pkg::*;

    cell_t                   chain [PALETTE_SIZE+1];
    logic [PALETTE_SIZE-1:0] match;
    logic [IDX_W-1:0]        pos;

    assign chain[0].occ   = 1'b1;
    assign chain[0].color = key;

    for (genvar k = 0; k < PALETTE_SIZE; k++)
    begin : g_cell
        prle_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .prev  (chain[k]),
            .key   (key),
            .cur   (chain[k+1]),
            .match (match[k])
        );
    end

    // stored colors are distinct, so at most one cell matches
    always_comb
    begin
        pos = '0;
        for (int k = 0; k < PALETTE_SIZE; k++)
        begin
            if (match[k])
            begin
                pos = pos | IDX_W'(k);
            end
        end
    end

    assign status.hit  = |match;
    assign status.pos  = pos;
    assign status.full = chain[PALETTE_SIZE].occ;

endmodule

/* design/palette_run_length_encoder_core.sv */
// ----------------------------------------------------------------------------
// palette_run_length_encoder_core
// RGB888 pixels in, run-length records with learned palette index out.
// ----------------------------------------------------------------------------
// Channel  Dir  Modport  Payload
// pixel    in   sink     red, green, blue, last_pixel
// record   out  source   run_length, color_index, color_565, new_color,
//                        palette_overflow, last_run
//
// Each pixel passes through accept, palette compare in all cells at once
// and run update; a pixel with last_pixel set adds a step for the final
// record. A new pixel is taken only after the previous one is through.
// Records leave through one output register; a pixel that must emit waits
// in the update step, and the final step waits, while that register is full.
// Reset (rst_n low, async) empties the palette and closes any run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module palette_run_length_encoder_core (
    input  logic          clk,
    input  logic          rst_n,
    prle_pixel_if.sink    pixel,
    prle_record_if.source record
);
    import prle_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_LAST   = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [COLOR_W-1:0]       px_color_reg;
    logic                     px_last_reg;
    logic                     hit_reg;
    logic [IDX_W-1:0]         pos_reg;

    // open run
    logic                     run_open_reg, run_open_next;
    logic [COLOR_W-1:0]       run_color_reg, run_color_next;
    logic [RUN_W-1:0]         run_count_reg, run_count_next;
    logic [COLOR_INDEX_W-1:0] run_index_reg, run_index_next;
    logic                     run_new_reg, run_new_next;
    logic                     run_ovf_reg, run_ovf_next;
    logic [USED_W-1:0]        used_reg, used_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    record_t                  out_rec_reg;
    record_t                  out_rec_next;
    logic                     out_load;
    logic                     out_free;

    pal_ctrl_t                pal_ctrl;
    pal_status_t              pal_status;

    logic                     accept;
    logic                     same_run;
    logic                     need_emit;
    logic [USED_W-1:0]        hit_index;
    logic                     last_done;

    assign accept   = pixel.valid && pixel.ready;
    assign out_free = !out_valid_reg || record.ready;

    prle_palette u_palette (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (pal_ctrl),
        .key    (px_color_reg),
        .status (pal_status)
    );

    // run continues if color matches and the count has room
    assign same_run  = run_open_reg && (px_color_reg == run_color_reg)
                     && (run_count_reg != MAX_RUN);
    assign need_emit = run_open_reg && !same_run;
    // newest color lives in cell 0, so index counts back from the fill level
    assign hit_index = used_reg - USED_W'(1) - USED_W'(pos_reg);
    // final record is loaded into the output register this cycle
    assign last_done = (state_reg == ST_LAST) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        run_open_next  = run_open_reg;
        run_color_next = run_color_reg;
        run_count_next = run_count_reg;
        run_index_next = run_index_reg;
        run_new_next   = run_new_reg;
        run_ovf_next   = run_ovf_reg;
        used_next      = used_reg;
        out_load       = 1'b0;
        out_rec_next   = out_rec_reg;
        pal_ctrl       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!need_emit || out_free)
                begin
                    if (need_emit)
                    begin
                        out_load     = 1'b1;
                        out_rec_next = '{run_length:       run_count_reg,
                                         color_index:      run_index_reg,
                                         color_565:        run_color_reg,
                                         new_color:        run_new_reg,
                                         palette_overflow: run_ovf_reg,
                                         last_run:         1'b0};
                    end
                    if (same_run)
                    begin
                        run_count_next = run_count_reg + RUN_W'(1);
                    end
                    else
                    begin
                        run_open_next  = 1'b1;
                        run_color_next = px_color_reg;
                        run_count_next = RUN_W'(1);
                        run_new_next   = 1'b0;
                        run_ovf_next   = 1'b0;
                        priority if (hit_reg)
                        begin
                            run_index_next = COLOR_INDEX_W'(hit_index[IDX_W-1:0]);
                        end
                        else if (!pal_status.full)
                        begin
                            pal_ctrl.shift = 1'b1;
                            run_index_next = COLOR_INDEX_W'(used_reg[IDX_W-1:0]);
                            run_new_next   = 1'b1;
                            used_next      = used_reg + USED_W'(1);
                        end
                        else
                        begin
                            run_index_next = '0;
                            run_ovf_next   = 1'b1;
                        end
                    end
                    state_next = px_last_reg ? ST_LAST : ST_IDLE;
                end
            end
            ST_LAST:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_rec_next   = '{run_length:       run_count_reg,
                                       color_index:      run_index_reg,
                                       color_565:        run_color_reg,
                                       new_color:        run_new_reg,
                                       palette_overflow: run_ovf_reg,
                                       last_run:         1'b1};
                    run_open_next  = 1'b0;
                    used_next      = '0;
                    pal_ctrl.clear = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (record.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_open_reg  <= 1'b0;
            run_color_reg <= '0;
            run_count_reg <= '0;
            run_index_reg <= '0;
            run_new_reg   <= 1'b0;
            run_ovf_reg   <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_open_reg  <= run_open_next;
            run_color_reg <= run_color_next;
            run_count_reg <= run_count_next;
            run_index_reg <= run_index_next;
            run_new_reg   <= run_new_next;
            run_ovf_reg   <= run_ovf_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_color_reg <= to565(pixel.red, pixel.green, pixel.blue);
            px_last_reg  <= pixel.last_pixel;
        end
        if (state_reg == ST_LOOKUP)
        begin
            hit_reg <= pal_status.hit;
            pos_reg <= pal_status.pos;
        end
        if (out_load)
        begin
            out_rec_reg <= out_rec_next;
        end
    end

    assign pixel.ready             = (state_reg == ST_IDLE);
    assign record.valid            = out_valid_reg;
    assign record.run_length       = out_rec_reg.run_length;
    assign record.color_index      = out_rec_reg.color_index;
    assign record.color_565        = out_rec_reg.color_565;
    assign record.new_color        = out_rec_reg.new_color;
    assign record.palette_overflow = out_rec_reg.palette_overflow;
    assign record.last_run         = out_rec_reg.last_run;

    // fill level never passes the palette depth
    `PRLE_ASSERT_IMPL(a_used_range, clk, rst_n, 1'b1, used_reg <= USED_W'(PALETTE_SIZE))
    // the final record closes the run and empties the palette
    `PRLE_ASSERT_NEXT(a_last_clears, clk, rst_n, last_done, !run_open_reg && (used_reg == '0))
    // a shown record never carries an empty run
    `PRLE_ASSERT_IMPL(a_run_nonzero, clk, rst_n, out_valid_reg, out_rec_reg.run_length != '0)

endmodule

/* dv/tb_palette_run_length_encoder_core.sv */
// ----------------------------------------------------------------------------
// tb_palette_run_length_encoder_core
// Self-checking bench for the palette run-length encoder. A directed table
// covers channel extremes, ignored low bits, a long single-color run, a full
// palette and end-of-image clearing. A random part follows, made mostly of
// well-formed images with random runs and some noise. Every run record is
// compared with a prediction, typed in the table or from an in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_palette_run_length_encoder_core;

    import prle_pkg::*;

    localparam int IDLE_LIMIT    = 2000;  // cycles with no transaction on either side
    localparam int RANDOM_PIXELS = 1450;
    localparam int MAX_REPORTS   = 10;
    localparam int TAIL_CYCLES   = 20;

    // Directed row kinds: one pixel, one color held for count pixels, or a
    // sweep of count distinct RGB565 colors starting at 0.
    typedef enum logic [1:0] {
        ROW_PIXEL,
        ROW_HOLD,
        ROW_SWEEP
    } row_kind_e;

    // n_typed 0 means the model supplies the expected records for the row.
    typedef struct packed {
        row_kind_e   kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
        logic [16:0] count;
        logic [1:0]  n_typed;
        record_t     first_exp;
        record_t     second_exp;
    } stim_row_t;

    localparam record_t NO_REC = '0;
    localparam int      N_ROWS = 16;

    // record fields: run_length, color_index, color_565, new_color,
    // palette_overflow, last_run
    localparam stim_row_t DIRECTED [N_ROWS] = '{
        // black as a one-pixel image, then white as another
        '{ROW_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1, 17'd1, 2'd1,
          '{16'd1, 8'd0, 16'h0000, 1'b1, 1'b0, 1'b1}, NO_REC},
        '{ROW_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1, 17'd1, 2'd1,
          '{16'd1, 8'd0, 16'hFFFF, 1'b1, 1'b0, 1'b1}, NO_REC},
        // low bits are dropped, so these two pixels are one black run
        '{ROW_PIXEL, 8'h07, 8'h03, 8'h07, 1'b0, 17'd1, 2'd0, NO_REC, NO_REC},
        '{ROW_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 17'd1, 2'd0, NO_REC, NO_REC},
        // pure red, green, blue learn indices 1..3
        '{ROW_PIXEL, 8'hF8, 8'h00, 8'h00, 1'b0, 17'd1, 2'd1,
          '{16'd2, 8'd0, 16'h0000, 1'b1, 1'b0, 1'b0}, NO_REC},
        '{ROW_PIXEL, 8'h00, 8'hFC, 8'h00, 1'b0, 17'd1, 2'd1,
          '{16'd1, 8'd1, 16'hF800, 1'b1, 1'b0, 1'b0}, NO_REC},
        '{ROW_PIXEL, 8'h00, 8'h00, 8'hF8, 1'b0, 17'd1, 2'd1,
          '{16'd1, 8'd2, 16'h07E0, 1'b1, 1'b0, 1'b0}, NO_REC},
        '{ROW_PIXEL, 8'hFF, 8'h00, 8'h00, 1'b0, 17'd1, 2'd1,
          '{16'd1, 8'd3, 16'h001F, 1'b1, 1'b0, 1'b0}, NO_REC},
        // known color closes with last: two records, neither new
        '{ROW_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1, 17'd1, 2'd2,
          '{16'd1, 8'd1, 16'hF800, 1'b0, 1'b0, 1'b0},
          '{16'd1, 8'd0, 16'h0000, 1'b0, 1'b0, 1'b1}},
        // long run: 30 equal pixels, then the same color closes the image
        '{ROW_HOLD,  8'h55, 8'hAA, 8'h33, 1'b0, 17'd30, 2'd0, NO_REC, NO_REC},
        '{ROW_PIXEL, 8'h55, 8'hAA, 8'h33, 1'b1, 17'd1, 2'd1,
          '{16'd31, 8'd0, 16'h5546, 1'b1, 1'b0, 1'b1}, NO_REC},
        // fill all 256 palette slots with colors 0..255
        '{ROW_SWEEP, 8'h00, 8'h00, 8'h00, 1'b0, 17'd256, 2'd0, NO_REC, NO_REC},
        // new color with a full palette
        '{ROW_PIXEL, 8'h10, 8'h44, 8'hA0, 1'b0, 17'd1, 2'd1,
          '{16'd1, 8'd255, 16'h00FF, 1'b1, 1'b0, 1'b0}, NO_REC},
        // known color still found after overflow
        '{ROW_PIXEL, 8'h00, 8'h00, 8'h28, 1'b0, 17'd1, 2'd1,
          '{16'd1, 8'd0, 16'h1234, 1'b0, 1'b1, 1'b0}, NO_REC},
        '{ROW_PIXEL, 8'hF8, 8'hFC, 8'hF8, 1'b1, 17'd1, 2'd2,
          '{16'd1, 8'd5, 16'h0005, 1'b0, 1'b0, 1'b0},
          '{16'd1, 8'd0, 16'hFFFF, 1'b0, 1'b1, 1'b1}},
        // palette starts over from index 0 on the next image
        '{ROW_PIXEL, 8'h10, 8'h20, 8'h30, 1'b1, 17'd1, 2'd1,
          '{16'd1, 8'd0, 16'h1106, 1'b1, 1'b0, 1'b1}, NO_REC}
    };

    logic clk;
    logic rst_n;

    prle_pixel_if  pixel_ch ();
    prle_record_if record_ch ();

    palette_run_length_encoder_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_ch),
        .record (record_ch)
    );

    // Encoder model state
    logic [COLOR_W-1:0] pal_color [PALETTE_SIZE];
    logic [USED_W-1:0]  pal_used;
    logic [COLOR_W-1:0] run_color;
    logic [RUN_W-1:0]   run_count;
    logic [IDX_W-1:0]   run_index;
    logic               run_is_new;
    logic               run_ovf;
    logic               run_open;

    record_t pending_runs [$];   // records predicted but not yet seen
    int      errors;
    int      idle_cycles;
    bit      no_idle;            // both sides run flat out while set

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Record for the run that is open right now
    function automatic record_t closed_run(input logic last);
        return '{run_count, run_index, run_color, run_is_new, run_ovf, last};
    endfunction

    // Append a predicted record at the tail
    function automatic void queue_record(input record_t rec);
        pending_runs = {pending_runs, rec};
    endfunction

    // Advance the model by one pixel; returns how many records it closes.
    // When there are two, older is the previous run and newer the final one.
    function automatic int encode_pixel(input logic [23:0] px, input logic last,
                                        output record_t older, output record_t newer);
        logic [COLOR_W-1:0] c;
        int                 n;
        bit                 found;
        c     = {px[23:19], px[15:10], px[7:3]};
        n     = 0;
        older = NO_REC;
        newer = NO_REC;
        if (run_open && c == run_color && run_count != MAX_RUN)
        begin
            run_count++;
        end
        else
        begin
            if (run_open)
            begin
                older = closed_run(1'b0);
                n     = 1;
            end
            run_color  = c;
            run_count  = RUN_W'(1);
            run_index  = '0;
            run_is_new = 1'b0;
            run_ovf    = 1'b0;
            found      = 0;
            for (int i = 0; i < PALETTE_SIZE; i++)
            begin
                if (!found && i < pal_used && pal_color[i] == c)
                begin
                    run_index = IDX_W'(i);
                    found     = 1;
                end
            end
            if (!found)
            begin
                if (pal_used < PALETTE_SIZE)
                begin
                    pal_color[pal_used[IDX_W-1:0]] = c;
                    run_index                      = pal_used[IDX_W-1:0];
                    run_is_new                     = 1'b1;
                    pal_used++;
                end
                else
                begin
                    run_ovf = 1'b1;
                end
            end
            run_open = 1'b1;
        end
        if (last)
        begin
            if (n == 0)
                older = closed_run(1'b1);
            else
                newer = closed_run(1'b1);
            n++;
            run_open = 1'b0;
            pal_used = '0;
        end
        return n;
    endfunction

    // RGB888 pixel for an RGB565 color, with random bits below the cut
    function automatic logic [23:0] pixel_of(input logic [COLOR_W-1:0] c);
        return {c[15:11], 3'($urandom), c[10:5], 2'($urandom), c[4:0], 3'($urandom)};
    endfunction

    // Present one pixel after a random gap and hold it until taken. The
    // model is stepped in the same time step as the transaction, which is
    // well before any record for that pixel can come out.
    task automatic drive_pixel(input logic [23:0] px, input logic last, output int n,
                               output record_t older, output record_t newer);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid      <= 1'b1;
        pixel_ch.red        <= px[23:16];
        pixel_ch.green      <= px[15:8];
        pixel_ch.blue       <= px[7:0];
        pixel_ch.last_pixel <= last;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        n = encode_pixel(px, last, older, newer);
    endtask

    task automatic send_pixel(input logic [23:0] px, input logic last);
        int      n;
        record_t older;
        record_t newer;
        drive_pixel(px, last, n, older, newer);
        if (n > 0)
            queue_record(older);
        if (n > 1)
            queue_record(newer);
    endtask

    // Hold the pixel side off until every predicted record has come out.
    // Always waits on the clock before returning, so valid never gets two
    // updates in one time step.
    task automatic wait_drain();
        pixel_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_runs.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table, then random images
    // ------------------------------------------------------------------------
    initial
    begin
        stim_row_t          row;
        record_t            older;
        record_t            newer;
        logic [COLOR_W-1:0] colors [8];
        logic [COLOR_W-1:0] base;
        logic [COLOR_W-1:0] stride;
        logic               last;
        int                 n;
        int                 sent;
        int                 mode;
        int                 len;
        int                 ncol;
        int                 nruns;
        int                 pick;

        errors     = 0;
        no_idle    = 0;
        pal_used   = '0;
        run_color  = '0;
        run_count  = '0;
        run_index  = '0;
        run_is_new = 1'b0;
        run_ovf    = 1'b0;
        run_open   = 1'b0;

        rst_n               <= 1'b0;
        pixel_ch.valid      <= 1'b0;
        pixel_ch.red        <= '0;
        pixel_ch.green      <= '0;
        pixel_ch.blue       <= '0;
        pixel_ch.last_pixel <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Rows with typed records push those; the model is
        // still stepped so its state follows the block.
        for (int i = 0; i < N_ROWS; i++)
        begin
            row     = DIRECTED[i];
            no_idle = (row.kind == ROW_HOLD);   // back-to-back pixels inside one run
            for (int k = 0; k < row.count; k++)
            begin
                last = row.last && (k == row.count - 1);
                if (row.kind == ROW_SWEEP)
                begin
                    send_pixel(pixel_of(COLOR_W'(k)), last);
                end
                else if (row.n_typed == 0)
                begin
                    send_pixel({row.red, row.green, row.blue}, last);
                end
                else
                begin
                    drive_pixel({row.red, row.green, row.blue}, last, n, older, newer);
                    queue_record(row.first_exp);
                    if (row.n_typed == 2)
                        queue_record(row.second_exp);
                end
            end
        end
        no_idle = 0;
        wait_drain();

        // Random images. Most are well formed (a few colors in short runs,
        // closed by last_pixel); the rest are many-color images, raw noise
        // with stray last_pixel, and now and then an image that overruns
        // the palette.
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            mode    = $urandom_range(0, 39);
            no_idle = ($urandom_range(0, 4) == 0);
            if (mode == 0)
            begin
                base   = COLOR_W'($urandom);
                stride = COLOR_W'($urandom) | COLOR_W'(1);   // odd: all distinct
                len    = $urandom_range(PALETTE_SIZE + 1, PALETTE_SIZE + 24);
                for (int k = 0; k < len; k++)
                    send_pixel(pixel_of(base + COLOR_W'(k) * stride), 1'b0);
                for (int k = 0; k < 4; k++)
                begin
                    pick = $urandom_range(0, len - 1);
                    send_pixel(pixel_of(base + COLOR_W'(pick) * stride), k == 3);
                end
                sent += len + 4;
            end
            else if (mode <= 4)
            begin
                len = $urandom_range(20, 80);
                for (int k = 0; k < len; k++)
                    send_pixel(24'($urandom), k == len - 1);
                sent += len;
            end
            else if (mode <= 8)
            begin
                len = $urandom_range(1, 20);
                for (int k = 0; k < len; k++)
                    send_pixel(24'($urandom), $urandom_range(0, 5) == 0);
                sent += len;
            end
            else
            begin
                ncol = $urandom_range(1, 8);
                for (int j = 0; j < ncol; j++)
                begin
                    case ($urandom_range(0, 9))
                        0:       colors[j] = '0;
                        1:       colors[j] = '1;
                        default: colors[j] = COLOR_W'($urandom);
                    endcase
                end
                nruns = $urandom_range(1, 12);
                for (int r = 0; r < nruns; r++)
                begin
                    pick = $urandom_range(0, ncol - 1);
                    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                       : $urandom_range(1, 6);
                    for (int k = 0; k < len; k++)
                        send_pixel(pixel_of(colors[pick]),
                                   (r == nruns - 1) && (k == len - 1));
                    sent += len;
                end
            end
            if ($urandom_range(0, 7) == 0)
                wait_drain();
        end

        // Let the tail drain, then keep watching for stray records
        no_idle = 0;
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        while (pending_runs.size() != 0)
        begin
            record_t lost;
            lost = pending_runs.pop_front();
            errors++;
            if (errors <= MAX_REPORTS)
                $display("missing record: len=%0d idx=%0d color=%h new=%b ovf=%b last=%b",
                         lost.run_length, lost.color_index, lost.color_565,
                         lost.new_color, lost.palette_overflow, lost.last_run);
        end
        if (errors == 0)
            $display("[palette_run_length_encoder_core] OK");
        else
            $display("[palette_run_length_encoder_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Record side: random stalls on ready, each transaction checked against
    // the oldest prediction
    // ------------------------------------------------------------------------
    initial
    begin
        record_t got;
        record_t want;
        int      stall;
        bit      same;

        record_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                record_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            record_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!record_ch.valid);
            got = '{record_ch.run_length, record_ch.color_index, record_ch.color_565,
                    record_ch.new_color, record_ch.palette_overflow, record_ch.last_run};
            if (pending_runs.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected record: len=%0d idx=%0d color=%h new=%b ovf=%b last=%b",
                             got.run_length, got.color_index, got.color_565,
                             got.new_color, got.palette_overflow, got.last_run);
            end
            else
            begin
                want = pending_runs.pop_front();
                same = (got.run_length === want.run_length)
                    && (got.color_index === want.color_index)
                    && (got.color_565 === want.color_565)
                    && (got.new_color === want.new_color)
                    && (got.palette_overflow === want.palette_overflow)
                    && (got.last_run === want.last_run);
                if (!same)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("record mismatch at %0t", $realtime);
                        $display("  expected len=%0d idx=%0d color=%h new=%b ovf=%b last=%b",
                                 want.run_length, want.color_index, want.color_565,
                                 want.new_color, want.palette_overflow, want.last_run);
                        $display("  actual   len=%0d idx=%0d color=%h new=%b ovf=%b last=%b",
                                 got.run_length, got.color_index, got.color_565,
                                 got.new_color, got.palette_overflow, got.last_run);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long with no transaction on either channel ends the run
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((pixel_ch.valid && pixel_ch.ready) || (record_ch.valid && record_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("[palette_run_length_encoder_core] ERROR");
                $finish;
            end
        end
    end

endmodule
